/* sv/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and constants for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_BITS      = 16;

    localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
    localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
    localparam int TURN_UNITS   = 360 << HUE_FRAC_BITS;
    localparam int SCALE_DEN    = SECTOR_UNITS * CHAN_MAX;

    // SCALE_DEN is 2^8 times an odd factor; the odd part is divided by a
    // reciprocal estimate that is fixed up by one compare.
    localparam int DEN_LO_SHIFT = 8;
    localparam int DEN_ODD      = SCALE_DEN >> DEN_LO_SHIFT;
    localparam int Q_RECIP      = (1 << 27) / DEN_ODD;
    localparam int Q_RECIP_SH   = 23;

    // Exact floor(x / 255) for any 16-bit x: (x * 0x8081) >> 23.
    localparam int P_RECIP    = 32897;
    localparam int P_RECIP_SH = 23;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [HUE_BITS-1:0]     hue_t;
    typedef logic [14:0]             hred_t;    // hue reduced to one turn
    typedef logic [11:0]             rem_t;     // position inside a sector
    typedef logic [19:0]             num_t;     // numerator terms up to SCALE_DEN
    typedef logic [27:0]             prod_t;    // level times numerator
    typedef logic [15:0]             pprod_t;   // level times (max - saturation)

    typedef enum logic [2:0] {
        SECTOR_RY = 3'd0,
        SECTOR_YG = 3'd1,
        SECTOR_GC = 3'd2,
        SECTOR_CB = 3'd3,
        SECTOR_BM = 3'd4,
        SECTOR_MR = 3'd5
    } sector_t;

    typedef struct packed {
        hue_t  hue;
        chan_t sat;
        chan_t val;
    } hsv_t;

    typedef struct packed {
        sector_t sector;
        rem_t    rem;
        chan_t   sat;
        chan_t   val;
    } sect_info_t;

    typedef struct packed {
        sector_t sector;
        chan_t   val;
        chan_t   p;
        chan_t   q_est;
        num_t    q_y;
        chan_t   t_est;
        num_t    t_y;
    } scaled_t;

endpackage

/* sv/hsv2rgb_hue_reduce.sv */
// ----------------------------------------------------------------------------
// Hue reduction stages
// Reduces the hue to one turn, then splits it into sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_reduce (
    input  logic                    aclk,
    input  logic [1:0]              stage_en,
    input  hsv2rgb_pkg::hsv_t       hsv_in,
    output hsv2rgb_pkg::sect_info_t info_out
);

    localparam int TWO_TURNS = 2 * hsv2rgb_pkg::TURN_UNITS;

    hsv2rgb_pkg::hred_t   hred_reg, hred_next;
    hsv2rgb_pkg::chan_t   sat_reg, val_reg;
    hsv2rgb_pkg::sect_info_t info_reg, info_next;

    // A 16-bit hue is below three turns, so two compares finish the modulo.
    always_comb begin
        if (32'(hsv_in.hue) >= TWO_TURNS) begin
            hred_next = hsv2rgb_pkg::hred_t'(32'(hsv_in.hue) - TWO_TURNS);
        end else if (32'(hsv_in.hue) >= hsv2rgb_pkg::TURN_UNITS) begin
            hred_next = hsv2rgb_pkg::hred_t'(32'(hsv_in.hue) - hsv2rgb_pkg::TURN_UNITS);
        end else begin
            hred_next = hsv2rgb_pkg::hred_t'(hsv_in.hue);
        end
    end

    always_comb begin
        hsv2rgb_pkg::hred_t base;
        base             = '0;
        info_next.sector = hsv2rgb_pkg::SECTOR_RY;
        for (int k = 1; k < 6; k++) begin
            if (32'(hred_reg) >= k * hsv2rgb_pkg::SECTOR_UNITS) begin
                info_next.sector = hsv2rgb_pkg::sector_t'(k);
                base             = hsv2rgb_pkg::hred_t'(k * hsv2rgb_pkg::SECTOR_UNITS);
            end
        end
        info_next.rem = hsv2rgb_pkg::rem_t'(hred_reg - base);
        info_next.sat = sat_reg;
        info_next.val = val_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hred_reg <= hred_next;
            sat_reg  <= hsv_in.sat;
            val_reg  <= hsv_in.val;
        end
        if (stage_en[1]) begin
            info_reg <= info_next;
        end
    end

    assign info_out = info_reg;

endmodule

/* sv/hsv2rgb_scale.sv */
// ----------------------------------------------------------------------------
// Level scaling stages
// Forms p exactly and quotient estimates for q and t over three stages.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
    input  logic                    aclk,
    input  logic [2:0]              stage_en,
    input  hsv2rgb_pkg::sect_info_t info_in,
    output hsv2rgb_pkg::scaled_t    scaled_out
);

    // Stage A: numerators.
    hsv2rgb_pkg::num_t    nq_reg, nq_next, nt_reg, nt_next;
    hsv2rgb_pkg::pprod_t  px_reg, px_next;
    hsv2rgb_pkg::sector_t sec_a_reg;
    hsv2rgb_pkg::chan_t   val_a_reg;

    // Stage B: products and p.
    hsv2rgb_pkg::prod_t   xq_reg, xq_next, xt_reg, xt_next;
    hsv2rgb_pkg::chan_t   p_reg, p_next;
    hsv2rgb_pkg::sector_t sec_b_reg;
    hsv2rgb_pkg::chan_t   val_b_reg;

    // Stage C: quotient estimates.
    hsv2rgb_pkg::scaled_t scaled_reg, scaled_next;

    always_comb begin
        hsv2rgb_pkg::num_t mq;
        hsv2rgb_pkg::num_t mt;
        mq = hsv2rgb_pkg::num_t'(info_in.rem) * hsv2rgb_pkg::num_t'(info_in.sat);
        mt = hsv2rgb_pkg::num_t'(hsv2rgb_pkg::SECTOR_UNITS - 32'(info_in.rem))
           * hsv2rgb_pkg::num_t'(info_in.sat);
        nq_next = hsv2rgb_pkg::num_t'(hsv2rgb_pkg::SCALE_DEN) - mq;
        nt_next = hsv2rgb_pkg::num_t'(hsv2rgb_pkg::SCALE_DEN) - mt;
        px_next = hsv2rgb_pkg::pprod_t'(info_in.val)
                * hsv2rgb_pkg::pprod_t'(hsv2rgb_pkg::chan_t'(hsv2rgb_pkg::CHAN_MAX) - info_in.sat);
    end

    always_comb begin
        logic [31:0] pm;
        xq_next = hsv2rgb_pkg::prod_t'(val_a_reg) * hsv2rgb_pkg::prod_t'(nq_reg);
        xt_next = hsv2rgb_pkg::prod_t'(val_a_reg) * hsv2rgb_pkg::prod_t'(nt_reg);
        pm      = 32'(px_reg) * 32'(hsv2rgb_pkg::P_RECIP);
        p_next  = pm[hsv2rgb_pkg::P_RECIP_SH +: hsv2rgb_pkg::CHANNEL_BITS];
    end

    // The estimate uses the top 16 bits of the shifted product; it is never
    // above the true quotient and at most one below it.
    always_comb begin
        logic [31:0] eq;
        logic [31:0] et;
        eq = 32'(xq_reg[27:12]) * 32'(hsv2rgb_pkg::Q_RECIP);
        et = 32'(xt_reg[27:12]) * 32'(hsv2rgb_pkg::Q_RECIP);
        scaled_next.sector = sec_b_reg;
        scaled_next.val    = val_b_reg;
        scaled_next.p      = p_reg;
        scaled_next.q_est  = eq[hsv2rgb_pkg::Q_RECIP_SH +: hsv2rgb_pkg::CHANNEL_BITS];
        scaled_next.q_y    = xq_reg[27:hsv2rgb_pkg::DEN_LO_SHIFT];
        scaled_next.t_est  = et[hsv2rgb_pkg::Q_RECIP_SH +: hsv2rgb_pkg::CHANNEL_BITS];
        scaled_next.t_y    = xt_reg[27:hsv2rgb_pkg::DEN_LO_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            nq_reg    <= nq_next;
            nt_reg    <= nt_next;
            px_reg    <= px_next;
            sec_a_reg <= info_in.sector;
            val_a_reg <= info_in.val;
        end
        if (stage_en[1]) begin
            xq_reg    <= xq_next;
            xt_reg    <= xt_next;
            p_reg     <= p_next;
            sec_b_reg <= sec_a_reg;
            val_b_reg <= val_a_reg;
        end
        if (stage_en[2]) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled_out = scaled_reg;

endmodule

/* sv/hsv2rgb_assemble.sv */
// ----------------------------------------------------------------------------
// Color assembly stage
// Corrects the q and t estimates and places the channels by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_assemble (
    input  logic                 aclk,
    input  logic                 stage_en,
    input  hsv2rgb_pkg::scaled_t scaled_in,
    output logic [23:0]          color
);

    hsv2rgb_pkg::chan_t q, t, r, g, b;
    logic [23:0]        color_reg, color_next;

    function automatic hsv2rgb_pkg::chan_t fix_quot(hsv2rgb_pkg::chan_t est,
                                                     hsv2rgb_pkg::num_t  y);
        hsv2rgb_pkg::num_t rest;
        rest = y - hsv2rgb_pkg::num_t'(est) * hsv2rgb_pkg::num_t'(hsv2rgb_pkg::DEN_ODD);
        if (rest >= hsv2rgb_pkg::num_t'(hsv2rgb_pkg::DEN_ODD)) begin
            return est + 1'b1;
        end
        return est;
    endfunction

    always_comb begin
        q = fix_quot(scaled_in.q_est, scaled_in.q_y);
        t = fix_quot(scaled_in.t_est, scaled_in.t_y);
        case (scaled_in.sector)
            hsv2rgb_pkg::SECTOR_RY: begin
                r = scaled_in.val; g = t;             b = scaled_in.p;
            end
            hsv2rgb_pkg::SECTOR_YG: begin
                r = q;             g = scaled_in.val; b = scaled_in.p;
            end
            hsv2rgb_pkg::SECTOR_GC: begin
                r = scaled_in.p;   g = scaled_in.val; b = t;
            end
            hsv2rgb_pkg::SECTOR_CB: begin
                r = scaled_in.p;   g = q;             b = scaled_in.val;
            end
            hsv2rgb_pkg::SECTOR_BM: begin
                r = t;             g = scaled_in.p;   b = scaled_in.val;
            end
            default: begin
                r = scaled_in.val; g = scaled_in.p;   b = q;
            end
        endcase
        color_next = {r, g, b};
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

/* sv/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Streams HSV colors in and packed 24-bit RGB words out, one per clock when neither side stalls.
// ----------------------------------------------------------------------------
// The slave channel takes one HSV color per transfer: hue in 1/64 degree
// steps (any 16-bit value, reduced modulo 360 degrees), saturation and
// brightness as 8-bit levels where 255 means full. The master channel gives
// one packed RGB word per input transfer, in the same order.
// The datapath is a six-stage pipeline: hue reduction, sector split,
// numerator products, level products, quotient estimate, and correction
// with channel placement into the output register. A color accepted into
// the first stage moves through the stage registers in this order and is
// presented on m_tvalid from the output register.
// Throughput is one transfer per clock while m_tready is high; each stage
// holds its own valid bit and refills whenever the stage after it moves,
// so bubbles are squeezed out while the output is stalled.
// When the receiver holds m_tready low, the result stays in the output
// register and the stages behind it keep filling; s_tready falls only once
// all six stages hold a color. Nothing is dropped or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline, which leaves
// s_tready high.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue [15:0], saturation [23:16], brightness [31:24]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // color [23:0] (red 23..16, green 15..8, blue 7..0)
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] stage_en;

    hsv2rgb_pkg::hsv_t       hsv_in;
    hsv2rgb_pkg::sect_info_t info;
    hsv2rgb_pkg::scaled_t    scaled;

    // A stage may load when it is empty or when its content moves on in
    // the same cycle.
    always_comb begin
        stage_en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign hsv_in.hue = s_tdata[15:0];
    assign hsv_in.sat = s_tdata[23:16];
    assign hsv_in.val = s_tdata[31:24];

    hsv2rgb_hue_reduce u_reduce (
        .aclk     (aclk),
        .stage_en (stage_en[1:0]),
        .hsv_in   (hsv_in),
        .info_out (info)
    );

    hsv2rgb_scale u_scale (
        .aclk       (aclk),
        .stage_en   (stage_en[4:2]),
        .info_in    (info),
        .scaled_out (scaled)
    );

    hsv2rgb_assemble u_assemble (
        .aclk      (aclk),
        .stage_en  (stage_en[5]),
        .scaled_in (scaled),
        .color     (m_tdata)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = vld_reg[STAGES-1];

    // A full pipeline with a stalled receiver must refuse new input.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline full and output stalled");

    // An accepted transfer lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer not captured by first stage");

    // A delivered result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !vld_reg[STAGES-2]) |=> !m_tvalid)
        else $error("result repeated after transfer");

    // An empty pipeline always accepts input.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '0) |-> s_tready)
        else $error("empty pipeline not ready");

endmodule

/* bench/hsv_to_rgb_converter_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches both stream channels, works out the RGB word for every accepted
// HSV color and compares each result transfer against the oldest one waiting.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // hue [15:0], saturation [23:16], brightness [31:24]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // color [23:0] (red 23..16, green 15..8, blue 7..0)
    output int          fail_count,
    output int          outstanding
);

    typedef struct {
        logic [31:0] hsv;
        logic [23:0] color;
    } pending_color_t;

    pending_color_t pending_colors[$];

    // Exact floored integer form of the usual HSV to RGB mapping.
    function automatic logic [23:0] rgb_of(hsv2rgb_pkg::hue_t hue, hsv2rgb_pkg::chan_t sat,
                                           hsv2rgb_pkg::chan_t val);
        longint unsigned turn_pos, rem, den, lvl, s, p, q, t;
        hsv2rgb_pkg::sector_t sector;
        hsv2rgb_pkg::chan_t r, g, b;
        turn_pos = longint'(hue) % hsv2rgb_pkg::TURN_UNITS;
        sector   = hsv2rgb_pkg::sector_t'(turn_pos / hsv2rgb_pkg::SECTOR_UNITS);
        rem      = turn_pos % hsv2rgb_pkg::SECTOR_UNITS;
        den      = hsv2rgb_pkg::SCALE_DEN;
        lvl      = val;
        s        = sat;
        p = lvl * (hsv2rgb_pkg::CHAN_MAX - s) / hsv2rgb_pkg::CHAN_MAX;
        q = lvl * (den - rem * s) / den;
        t = lvl * (den - (hsv2rgb_pkg::SECTOR_UNITS - rem) * s) / den;
        case (sector)
            hsv2rgb_pkg::SECTOR_RY: begin
                r = val; g = hsv2rgb_pkg::chan_t'(t); b = hsv2rgb_pkg::chan_t'(p);
            end
            hsv2rgb_pkg::SECTOR_YG: begin
                r = hsv2rgb_pkg::chan_t'(q); g = val; b = hsv2rgb_pkg::chan_t'(p);
            end
            hsv2rgb_pkg::SECTOR_GC: begin
                r = hsv2rgb_pkg::chan_t'(p); g = val; b = hsv2rgb_pkg::chan_t'(t);
            end
            hsv2rgb_pkg::SECTOR_CB: begin
                r = hsv2rgb_pkg::chan_t'(p); g = hsv2rgb_pkg::chan_t'(q); b = val;
            end
            hsv2rgb_pkg::SECTOR_BM: begin
                r = hsv2rgb_pkg::chan_t'(t); g = hsv2rgb_pkg::chan_t'(p); b = val;
            end
            default: begin
                r = val; g = hsv2rgb_pkg::chan_t'(p); b = hsv2rgb_pkg::chan_t'(q);
            end
        endcase
        return {r, g, b};
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pending_color_t head;
        if (!aresetn) begin
            pending_colors.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_colors.size() == 0) begin
                    report_mismatch($sformatf("color %06h arrived with nothing pending",
                                              m_tdata));
                end else begin
                    head = pending_colors.pop_front();
                    if (m_tdata !== head.color)
                        report_mismatch($sformatf(
                            "hsv %08h: color %06h, wanted %06h",
                            head.hsv, m_tdata, head.color));
                end
            end
            if (s_tvalid && s_tready) begin
                head.hsv   = s_tdata;
                head.color = rgb_of(s_tdata[15:0], s_tdata[23:16], s_tdata[31:24]);
                pending_colors.push_back(head);
            end
        end
        outstanding = pending_colors.size();
    end

endmodule

/* bench/hsv_to_rgb_converter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random HSV colors through the converter with random
// gaps on the input side and random back-pressure on the output side; the
// checker beside the block predicts and compares every RGB word.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

    // The slowest legal transfer waits out a full input gap, a full output
    // stall and the six-stage pipeline; this limit is many times that.
    localparam int STALL_LIMIT   = 400;
    localparam int RANDOM_COLORS = 1100;
    // Cycles allowed after the last expected color, to catch any extra one.
    localparam int DRAIN_CYCLES  = 24;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    // While calm is set neither side inserts gaps, so the pipeline runs
    // at full rate for a while.
    bit calm = 1'b0;

    always #6 aclk = ~aclk;

    hsv_to_rgb_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsv_to_rgb_converter_check checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: any transfer on either channel restarts the count. If the
    // block goes quiet for too long the run is declared failed.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("hsv_to_rgb_converter_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: before each result it holds m_tready low for a random number
    // of cycles, then keeps it high until a transfer takes place. Stalls
    // therefore land on every stage of a filling or draining pipeline.
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Sends one HSV color. It is entered at a falling edge and returns at the
    // falling edge after the transfer. When no gap is drawn, s_tvalid simply
    // stays high and the next color follows back to back.
    task automatic send_color(hsv2rgb_pkg::hue_t hue, hsv2rgb_pkg::chan_t sat,
                              hsv2rgb_pkg::chan_t val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, sat, hue};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Picks a channel level, leaning on the two ends of the range.
    function automatic hsv2rgb_pkg::chan_t pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return hsv2rgb_pkg::chan_t'(hsv2rgb_pkg::CHAN_MAX);
            default: return hsv2rgb_pkg::chan_t'($urandom_range(0, hsv2rgb_pkg::CHAN_MAX));
        endcase
    endfunction

    initial begin
        hsv2rgb_pkg::hue_t hue;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed colors: full turn and its multiples wrapping to red, hues on
        // and one step below sector borders, the middle of each sector, the top of
        // the hue range, greys from zero saturation, and the ends of both levels.
        send_color(16'd0,     8'd255, 8'd255);
        send_color(16'd0,     8'd0,   8'd0);
        send_color(16'd23040, 8'd255, 8'd255);
        send_color(16'd23039, 8'd255, 8'd255);
        send_color(16'd46080, 8'd170, 8'd85);
        send_color(16'd65535, 8'd255, 8'd255);
        send_color(16'd65535, 8'd0,   8'd128);
        send_color(16'd3839,  8'd255, 8'd200);
        send_color(16'd3840,  8'd255, 8'd200);
        send_color(16'd7680,  8'd128, 8'd255);
        send_color(16'd11520, 8'd255, 8'd255);
        send_color(16'd15360, 8'd200, 8'd100);
        send_color(16'd19199, 8'd1,   8'd254);
        send_color(16'd19200, 8'd255, 8'd255);
        send_color(16'd1920,  8'd255, 8'd255);
        send_color(16'd5760,  8'd255, 8'd255);
        send_color(16'd9600,  8'd255, 8'd255);
        send_color(16'd13440, 8'd255, 8'd255);
        send_color(16'd17280, 8'd255, 8'd255);
        send_color(16'd21120, 8'd255, 8'd255);
        send_color(16'd12345, 8'd0,   8'd255);
        send_color(16'd40000, 8'd255, 8'd0);
        send_color(16'd1,     8'd1,   8'd1);
        send_color(16'd64000, 8'd127, 8'd128);

        // Random colors. Every so often the run switches into or out of a
        // calm stretch where neither side idles.
        for (int i = 0; i < RANDOM_COLORS; i++) begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                6, 7:    hue = hsv2rgb_pkg::hue_t'($urandom_range(0, 17)
                                                   * hsv2rgb_pkg::SECTOR_UNITS
                                                   + $urandom_range(0, 2) - 1);
                8:       hue = hsv2rgb_pkg::hue_t'($urandom_range(0, 2)
                                                   * hsv2rgb_pkg::TURN_UNITS
                                                   + $urandom_range(0, 2) - 1);
                9:       hue = hsv2rgb_pkg::hue_t'($urandom_range(0,
                                                   hsv2rgb_pkg::TURN_UNITS - 1));
                default: hue = hsv2rgb_pkg::hue_t'($urandom_range(0, 65535));
            endcase
            send_color(hue, pick_level(), pick_level());
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Wait for every expected color, then a little longer so a stray
        // extra result would still be caught.
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("hsv_to_rgb_converter_test: clean");
        end else begin
            $display("hsv_to_rgb_converter_test: errors");
        end
        $finish;
    end

endmodule
